### rtl/msxt_pkg.sv
`timescale 1ns / 1ps

package msxt_pkg;

  // Field widths fixed by the item format
  localparam int unsigned VALUE_W = 30;
  // Working width for resizing between WIDTH and the field width
  localparam int unsigned EXT_W = 32;

  // Parameter defaults
  localparam int unsigned WIDTH_DEF = 30;
  localparam int unsigned MAX_ITEMS_DEF = 1024;
  localparam int unsigned NODE_COUNT_DEF = 32768;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] prefix_xor;
    logic [VALUE_W-1:0] best_ending_here;
    logic [VALUE_W-1:0] best_so_far;
    logic               store_full;
  } out_item_t;

endpackage

### rtl/msxt_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module msxt_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/max_subarray_xor_trie.sv
`timescale 1ns / 1ps

// Steps: accept, a query walk of up to WIDTH levels, an insert walk (skipped if the store is full),
//   and a result step held while the output stalls; in_stall_o holds new items off until it is done.
//   Query levels and insert levels on existing nodes use the single read port of the node RAM.
// Reset: asynchronous, clears prefix, best, item count and the root (held in flops) and sets the
//   free pointer to 1. The node RAM is not cleared; nodes are written as they are allocated.
module max_subarray_xor_trie #(
  parameter int unsigned WIDTH      = msxt_pkg::WIDTH_DEF,
  parameter int unsigned MAX_ITEMS  = msxt_pkg::MAX_ITEMS_DEF,
  parameter int unsigned NODE_COUNT = msxt_pkg::NODE_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  msxt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output msxt_pkg::out_item_t out_item_o
);

  localparam int unsigned IDX_W   = $clog2(NODE_COUNT);
  localparam int unsigned FREE_W  = IDX_W + 1;
  localparam int unsigned SUM_W   = IDX_W + 2;
  localparam int unsigned ENTRY_W = 2 * IDX_W;
  localparam int unsigned LVL_W   = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int unsigned ITEM_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned EXT_W   = msxt_pkg::EXT_W;
  localparam int unsigned VALUE_W = msxt_pkg::VALUE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_INSERT,
    ST_ALLOC,
    ST_FINISH
  } state_e;

  typedef logic [1:0][IDX_W-1:0] entry_t;

  state_e              state_q, state_d;
  entry_t              root_q, root_d;
  logic [FREE_W-1:0]   free_q, free_d;
  logic [WIDTH-1:0]    prefix_q, prefix_d;
  logic [WIDTH-1:0]    best_q, best_d;
  logic [ITEM_W-1:0]   items_q, items_d;
  logic [WIDTH-1:0]    key_q, key_d;
  logic [WIDTH-1:0]    acc_q, acc_d;
  logic [LVL_W-1:0]    level_q, level_d;
  logic [IDX_W-1:0]    node_q, node_d;
  logic                at_root_q, at_root_d;
  logic                full_q, full_d;
  logic                out_valid_q, out_valid_d;
  msxt_pkg::out_item_t out_q, out_d;

  // Node RAM ports
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  msxt_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entry of the node under the walk: root flops or last RAM read
  entry_t           cur;
  logic             key_bit, alloc_bit;
  logic [IDX_W-1:0] away, same, step_nxt, new_node;
  entry_t           entry_mod;
  logic [LVL_W-1:0] level_m1;

  assign cur       = at_root_q ? root_q : entry_t'(ram_rdata);
  assign key_bit   = key_q[level_q];
  assign level_m1  = level_q - LVL_W'(1);
  assign alloc_bit = key_q[level_m1];
  assign away      = cur[~key_bit];
  assign same      = cur[key_bit];
  assign new_node  = free_q[IDX_W-1:0];

  // Accept-time values, with restart applied first
  logic [EXT_W-1:0]  val_ext;
  logic [WIDTH-1:0]  prefix_base, items_pad;
  logic [FREE_W-1:0] free_eff;
  logic [ITEM_W-1:0] items_eff;
  logic [SUM_W-1:0]  free_sum;
  logic              ins_ok;

  assign val_ext     = EXT_W'(in_item_i.value);
  assign prefix_base = in_item_i.restart ? '0 : prefix_q;
  assign free_eff    = in_item_i.restart ? FREE_W'(1) : free_q;
  assign items_eff   = in_item_i.restart ? '0 : items_q;
  assign free_sum    = SUM_W'(free_eff) + SUM_W'(WIDTH);
  assign ins_ok      = (items_eff < ITEM_W'(MAX_ITEMS)) && (free_sum <= SUM_W'(NODE_COUNT));
  assign items_pad   = '0;

  // Result values
  logic [WIDTH-1:0] here, best_new;
  logic [EXT_W-1:0] prefix_ext, here_ext, best_ext;

  assign here       = (acc_q > key_q) ? acc_q : key_q;
  assign best_new   = (here > best_q) ? here : best_q;
  assign prefix_ext = EXT_W'(key_q);
  assign here_ext   = EXT_W'(here);
  assign best_ext   = EXT_W'(best_new);

  // Sequencer: query walk, then insert walk, then result
  always_comb begin
    state_d     = state_q;
    root_d      = root_q;
    free_d      = free_q;
    prefix_d    = prefix_q;
    best_d      = best_q;
    items_d     = items_q;
    key_d       = key_q;
    acc_d       = acc_q;
    level_d     = level_q;
    node_d      = node_q;
    at_root_d   = at_root_q;
    full_d      = full_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = '0;
    ram_raddr   = same;
    step_nxt    = same;
    entry_mod   = cur;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d    = prefix_base ^ val_ext[WIDTH-1:0];
          prefix_d = prefix_base ^ val_ext[WIDTH-1:0];
          if (in_item_i.restart) begin
            root_d  = '0;
            free_d  = FREE_W'(1);
            best_d  = items_pad;
            items_d = '0;
          end
          full_d    = !ins_ok;
          level_d   = LVL_W'(WIDTH - 1);
          at_root_d = 1'b1;
          acc_d     = '0;
          state_d   = ST_QUERY;
        end
      end

      // One level per cycle, preferring the opposite branch
      ST_QUERY: begin
        if (away != '0) begin
          acc_d[level_q] = 1'b1;
          step_nxt       = away;
        end
        if (((away != '0) || (same != '0)) && (level_q != '0)) begin
          ram_re    = 1'b1;
          ram_raddr = step_nxt;
          node_d    = step_nxt;
          at_root_d = 1'b0;
          level_d   = level_m1;
        end else begin
          level_d   = LVL_W'(WIDTH - 1);
          at_root_d = 1'b1;
          state_d   = full_q ? ST_FINISH : ST_INSERT;
        end
      end

      // Follow existing nodes; link a new one at the first gap
      ST_INSERT: begin
        if (same != '0) begin
          if (level_q == '0) begin
            items_d = items_q + ITEM_W'(1);
            state_d = ST_FINISH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = same;
            node_d    = same;
            at_root_d = 1'b0;
            level_d   = level_m1;
          end
        end else begin
          entry_mod[key_bit] = new_node;
          if (at_root_q) begin
            root_d = entry_mod;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = node_q;
            ram_wdata = ENTRY_W'(entry_mod);
          end
          free_d  = free_q + FREE_W'(1);
          node_d  = new_node;
          state_d = ST_ALLOC;
        end
      end

      // Write each fresh node of the new path, the leaf as empty
      ST_ALLOC: begin
        entry_mod = '0;
        ram_we    = 1'b1;
        ram_waddr = node_q;
        if (level_q == '0) begin
          ram_wdata = '0;
          items_d   = items_q + ITEM_W'(1);
          state_d   = ST_FINISH;
        end else begin
          entry_mod[alloc_bit] = new_node;
          ram_wdata = ENTRY_W'(entry_mod);
          free_d    = free_q + FREE_W'(1);
          node_d    = new_node;
          level_d   = level_m1;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.prefix_xor       = prefix_ext[VALUE_W-1:0];
          out_d.best_ending_here = here_ext[VALUE_W-1:0];
          out_d.best_so_far      = best_ext[VALUE_W-1:0];
          out_d.store_full       = full_q;
          out_valid_d            = 1'b1;
          best_d                 = best_new;
          state_d                = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      root_q      <= '0;
      free_q      <= FREE_W'(1);
      prefix_q    <= '0;
      best_q      <= '0;
      items_q     <= '0;
      key_q       <= '0;
      acc_q       <= '0;
      level_q     <= '0;
      node_q      <= '0;
      at_root_q   <= 1'b1;
      full_q      <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      root_q      <= root_d;
      free_q      <= free_d;
      prefix_q    <= prefix_d;
      best_q      <= best_d;
      items_q     <= items_d;
      key_q       <= key_d;
      acc_q       <= acc_d;
      level_q     <= level_d;
      node_q      <= node_d;
      at_root_q   <= at_root_d;
      full_q      <= full_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // No read of an entry in the cycle it is rewritten
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("node RAM read and write hit the same entry");

  // Free pointer stays inside the node store
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FREE_W'(NODE_COUNT))
    else $error("free node pointer beyond node store");

  // Item count saturates at the limit
  a_items_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    items_q <= ITEM_W'(MAX_ITEMS))
    else $error("item count beyond limit");

  // Running best never below the best ending here
  a_best_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.best_so_far >= out_q.best_ending_here))
    else $error("best so far below best ending here");

  // A result is only loaded from the finish step
  a_load_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !out_valid_q) |-> (state_q == ST_FINISH))
    else $error("result loaded outside finish step");
`endif

endmodule
